[rtl/core/bmh_pkg.sv]
// Package for the binary max-heap priority queue.
// Holds field widths, operation and status codes, and the sequencer state type.
// No dependencies; every other file of the block refers to it by scoped names.
package bmh_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(1024);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_ROOT,
    S_RM_LAST,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_RDR,
    S_DN_CMPR,
    S_DN_CMPX,
    S_DONE
  } state_t;

endpackage

[rtl/core/bmh_if.sv]
// Channel interfaces of the heap: the command word in and the result word out.
// Depends on bmh_pkg for the field widths.
interface bmh_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [bmh_pkg::VALUE_W-1:0]  value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface bmh_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [bmh_pkg::VALUE_W-1:0]  removed_value;
  logic [bmh_pkg::STATUS_W-1:0]        status;
  logic [bmh_pkg::COUNT_W-1:0]         element_count;

  modport source (output valid, removed_value, status, element_count, input ready);
  modport sink   (input valid, removed_value, status, element_count, output ready);
endinterface

[rtl/core/binary_max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue: sequencer, shared comparator
// and result register. Depends on bmh_pkg, bmh_cmd_if, bmh_res_if and bmh_store.
//
// Usage. Command words arrive on cmd (valid/ready): func selects insert or
// remove-maximum, value is the signed element to insert. Every command word
// yields exactly one result word on res (valid/ready): the removed maximum
// (-1 for a remove from an empty heap, 0 for an insert), a status code
// (ok, full so the insert was dropped, or empty remove) and the element count
// after the command. The user must write the capacity register through
// cfg_wr_en and cfg_wr_data only while the block is idle, which the block does
// not enforce; the effective capacity is the smaller of that value and DEPTH.
// Datapath. Elements live in a memory with one read and one write port, and one
// signed comparator is reused for every decision. An insert climbs level by
// level: it reads the parent and moves it down into the hole while the new
// element is larger, and stops at the root. A remove moves the last element to
// the root and sifts it down: per level it reads the left and, if present, the
// right child, compares the children and compares the larger against the moving
// element. Dropped inserts and empty removes need no memory access. One
// command is in work at a time: cmd.ready is high only while the sequencer is
// idle, which it is again from the edge that loads the result register.
// Reset clears the element count to zero and sets the capacity to 1024; the
// memory is not cleared, since only positions up to the count are ever read.
// When the receiver stalls, the finished result waits in the output register
// and the next command is still taken; the sequencer only holds in its final
// state if a second result is ready before the first has been taken.
module binary_max_heap_priority_queue #(
  parameter int unsigned DEPTH = bmh_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bmh_pkg::COUNT_W-1:0]   cfg_wr_data,
  bmh_cmd_if.sink                       cmd,
  bmh_res_if.source                     res
);

  // Position width holds 1..DEPTH; address width indexes DEPTH entries.
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = (PW > bmh_pkg::COUNT_W) ? PW : bmh_pkg::COUNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] POS_ONE = PW'(1);

  bmh_pkg::state_t  state, state_next;
  bmh_pkg::status_t status;

  logic [PW-1:0]                      count;
  logic [PW-1:0]                      idx;
  logic [PW-1:0]                      cidx;
  logic [bmh_pkg::VALUE_W-1:0]        x;
  logic [bmh_pkg::VALUE_W-1:0]        child;
  logic [bmh_pkg::VALUE_W-1:0]        removed;
  logic [bmh_pkg::COUNT_W-1:0]        cap;

  // Memory port signals.
  logic                               rd_en;
  logic [PW-1:0]                      rd_pos;
  logic [bmh_pkg::VALUE_W-1:0]        rd_data;
  logic                               wr_en;
  logic [PW-1:0]                      wr_pos;
  logic [bmh_pkg::VALUE_W-1:0]        wr_data;

  // Shared signed comparator.
  logic signed [bmh_pkg::VALUE_W-1:0] cmp_a;
  logic signed [bmh_pkg::VALUE_W-1:0] cmp_b;
  logic                               cmp_gt;

  logic          accept;
  logic          full;
  logic          res_load;
  logic [CW-1:0] eff_cap;
  logic [PW:0]   left_pos;
  logic [PW:0]   right_pos;
  logic [PW:0]   count_w;
  logic [PW-1:0] parent_pos;

  assign cmp_gt = cmp_a > cmp_b;

  assign accept     = (state == bmh_pkg::S_IDLE) && cmd.valid;
  assign eff_cap    = (CW'(cap) > DEPTH_C) ? DEPTH_C : CW'(cap);
  assign full       = CW'(count) >= eff_cap;
  assign left_pos   = {idx, 1'b0};
  assign right_pos  = {idx, 1'b1};
  assign count_w    = {1'b0, count};
  assign parent_pos = idx >> 1;

  bmh_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_pos - POS_ONE)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (AW'(wr_pos - POS_ONE)),
    .wr_data (wr_data)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      bmh_pkg::S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.func == bmh_pkg::FUNC_INSERT) begin
            state_next = full ? bmh_pkg::S_DONE : bmh_pkg::S_UP_CHK;
          end else begin
            state_next = (count == '0) ? bmh_pkg::S_DONE : bmh_pkg::S_RM_ROOT;
          end
        end
      end
      bmh_pkg::S_RM_ROOT: state_next = bmh_pkg::S_RM_LAST;
      bmh_pkg::S_RM_LAST: state_next = bmh_pkg::S_DN_CHK;
      bmh_pkg::S_UP_CHK: begin
        state_next = (idx == POS_ONE) ? bmh_pkg::S_DONE : bmh_pkg::S_UP_CMP;
      end
      bmh_pkg::S_UP_CMP: begin
        state_next = cmp_gt ? bmh_pkg::S_UP_CHK : bmh_pkg::S_DONE;
      end
      bmh_pkg::S_DN_CHK: begin
        state_next = (left_pos > count_w) ? bmh_pkg::S_DONE : bmh_pkg::S_DN_RDR;
      end
      bmh_pkg::S_DN_RDR: begin
        state_next = (right_pos <= count_w) ? bmh_pkg::S_DN_CMPR : bmh_pkg::S_DN_CMPX;
      end
      bmh_pkg::S_DN_CMPR: state_next = bmh_pkg::S_DN_CMPX;
      bmh_pkg::S_DN_CMPX: begin
        state_next = cmp_gt ? bmh_pkg::S_DN_CHK : bmh_pkg::S_DONE;
      end
      bmh_pkg::S_DONE: begin
        if (res_load) begin
          state_next = bmh_pkg::S_IDLE;
        end
      end
      default: state_next = bmh_pkg::S_IDLE;
    endcase
  end

  // Memory ports, comparator operands and handshake outputs per state.
  always_comb begin
    cmd.ready = 1'b0;
    rd_en     = 1'b0;
    rd_pos    = POS_ONE;
    wr_en     = 1'b0;
    wr_pos    = idx;
    wr_data   = x;
    cmp_a     = x;
    cmp_b     = rd_data;
    res_load  = 1'b0;
    case (state)
      bmh_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        // Fetch the root as soon as a remove from a non-empty heap is taken.
        rd_en = cmd.valid && (cmd.func == bmh_pkg::FUNC_REMOVE) && (count != '0);
      end
      bmh_pkg::S_RM_ROOT: begin
        rd_en  = 1'b1;
        rd_pos = count;
      end
      bmh_pkg::S_UP_CHK: begin
        if (idx == POS_ONE) begin
          wr_en = 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_pos = parent_pos;
        end
      end
      bmh_pkg::S_UP_CMP: begin
        // The parent moves down into the hole when the new element is larger.
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = rd_data;
        end
      end
      bmh_pkg::S_DN_CHK: begin
        if (left_pos > count_w) begin
          // When the only element was removed there is nothing to put back.
          wr_en = (idx <= count);
        end else begin
          rd_en  = 1'b1;
          rd_pos = left_pos[PW-1:0];
        end
      end
      bmh_pkg::S_DN_RDR: begin
        if (right_pos <= count_w) begin
          rd_en  = 1'b1;
          rd_pos = right_pos[PW-1:0];
        end
      end
      bmh_pkg::S_DN_CMPR: begin
        // Right child wins only when strictly larger; ties keep the left child.
        cmp_a = rd_data;
        cmp_b = child;
      end
      bmh_pkg::S_DN_CMPX: begin
        cmp_a = child;
        cmp_b = x;
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = child;
        end
      end
      bmh_pkg::S_DONE: begin
        res_load = !res.valid || res.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmh_pkg::S_IDLE;
      count <= '0;
      cap   <= bmh_pkg::CAP_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (accept && (cmd.func == bmh_pkg::FUNC_INSERT) && !full) begin
        count <= count + POS_ONE;
      end
      if (state == bmh_pkg::S_RM_LAST) begin
        count <= count - POS_ONE;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      bmh_pkg::S_IDLE: begin
        if (cmd.valid) begin
          removed <= '0;
          status  <= bmh_pkg::STATUS_OK;
          idx     <= count + POS_ONE;
          x       <= cmd.value;
          if (cmd.func == bmh_pkg::FUNC_INSERT) begin
            if (full) begin
              status <= bmh_pkg::STATUS_FULL;
            end
          end else if (count == '0) begin
            removed <= '1;
            status  <= bmh_pkg::STATUS_EMPTY;
          end
        end
      end
      bmh_pkg::S_RM_ROOT: removed <= rd_data;
      bmh_pkg::S_RM_LAST: begin
        // The last element becomes the one that sifts down from the root.
        x   <= rd_data;
        idx <= POS_ONE;
      end
      bmh_pkg::S_UP_CMP: begin
        if (cmp_gt) begin
          idx <= parent_pos;
        end
      end
      bmh_pkg::S_DN_RDR: begin
        child <= rd_data;
        cidx  <= left_pos[PW-1:0];
      end
      bmh_pkg::S_DN_CMPR: begin
        if (cmp_gt) begin
          child <= rd_data;
          cidx  <= right_pos[PW-1:0];
        end
      end
      bmh_pkg::S_DN_CMPX: begin
        if (cmp_gt) begin
          idx <= cidx;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: parts the sequencer from a stalled receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.removed_value <= removed;
      res.status        <= status;
      res.element_count <= bmh_pkg::COUNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(count) <= DEPTH_C)
    else $error("element count exceeds the store depth");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_pos != '0) && (wr_pos <= count))
    else $error("store write outside the occupied positions");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.func == bmh_pkg::FUNC_INSERT) && !full)
      |=> (count == $past(count) + POS_ONE))
    else $error("accepted insert did not grow the count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res_load && (status == bmh_pkg::STATUS_EMPTY)) |-> (removed == '1))
    else $error("empty remove does not return -1");
`endif

endmodule

[rtl/core/bmh_store.sv]
// Element store of the heap: one write port and one read port with registered data.
// Depends on bmh_pkg for the element width.
module bmh_store #(
  parameter int unsigned DEPTH = bmh_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic [bmh_pkg::VALUE_W-1:0]        rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(DEPTH)-1:0]           wr_addr,
  input  logic [bmh_pkg::VALUE_W-1:0]        wr_data
);

  logic [bmh_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
